FILE: rtl/drbof_pkg.sv
// Shared types and constants for the directory record byte-order fixer.
// No dependencies; every other file refers to this package by scoped names.
package drbof_pkg;

   localparam int unsigned HEADER_BYTES   = 8;
   localparam int unsigned BUNDLE_BYTES   = 4;
   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [7:0] CLIENT_ORDER_RESET = 8'd228;
   localparam logic [7:0] SERVER_ORDER_RESET = 8'd228;

   typedef enum logic [2:0] {
      REG_CLIENT_ORDER         = 3'd0,
      REG_SERVER_ORDER         = 3'd1,
      REG_CLIENT_KNOWN         = 3'd2,
      REG_IS_DIRECTORY         = 3'd3,
      REG_NATIVE_LITTLE_ENDIAN = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_STOPPED = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] client_order;
      logic [7:0] server_order;
      logic       client_known;
      logic       is_directory;
      logic       native_little_endian;
   } cfg_type;

   // Up to four result bytes caused by one accepted input byte.
   typedef struct packed {
      logic [BUNDLE_BYTES-1:0][7:0] bytes;
      logic [1:0]                   last_idx;
      status_type                   status;
      logic                         last;
   } bundle_type;

endpackage

FILE: rtl/drbof_csr.sv
// Configuration registers behind the APB-style port.
// Depends on drbof_pkg for the register map and the cfg_type struct.
module drbof_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [drbof_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [drbof_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [drbof_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                  pready,
   output drbof_pkg::cfg_type                    cfg
);

   drbof_pkg::cfg_type       cfg_ff;
   drbof_pkg::cfg_type       cfg_in;
   drbof_pkg::reg_index_type reg_index;
   logic                     wr_en;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = drbof_pkg::reg_index_type'(paddr[4:2]);
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            drbof_pkg::REG_CLIENT_ORDER:         cfg_in.client_order = pwdata[7:0];
            drbof_pkg::REG_SERVER_ORDER:         cfg_in.server_order = pwdata[7:0];
            drbof_pkg::REG_CLIENT_KNOWN:         cfg_in.client_known = pwdata[0];
            drbof_pkg::REG_IS_DIRECTORY:         cfg_in.is_directory = pwdata[0];
            drbof_pkg::REG_NATIVE_LITTLE_ENDIAN: cfg_in.native_little_endian = pwdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_index)
         drbof_pkg::REG_CLIENT_ORDER:         prdata[7:0] = cfg_ff.client_order;
         drbof_pkg::REG_SERVER_ORDER:         prdata[7:0] = cfg_ff.server_order;
         drbof_pkg::REG_CLIENT_KNOWN:         prdata[0]   = cfg_ff.client_known;
         drbof_pkg::REG_IS_DIRECTORY:         prdata[0]   = cfg_ff.is_directory;
         drbof_pkg::REG_NATIVE_LITTLE_ENDIAN: prdata[0]   = cfg_ff.native_little_endian;
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.client_order         <= drbof_pkg::CLIENT_ORDER_RESET;
         cfg_ff.server_order         <= drbof_pkg::SERVER_ORDER_RESET;
         cfg_ff.client_known         <= 1'b0;
         cfg_ff.is_directory         <= 1'b0;
         cfg_ff.native_little_endian <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/drbof_front.sv
// Front end: accepts buffer bytes, tracks the record header and builds
// the bundle of result bytes each input byte causes. Depends on drbof_pkg.
module drbof_front (
   input  logic                  clock,
   input  logic                  reset,
   input  drbof_pkg::cfg_type    cfg,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output logic                  q_push,
   output drbof_pkg::bundle_type q_data
);

   logic [3:0][7:0] fbuf_ff;
   logic [3:0][7:0] fbuf_in;
   logic [15:0]     offset_ff;
   logic [15:0]     offset_in;
   logic [15:0]     length_ff;
   logic [15:0]     length_in;
   logic            stopped_ff;
   logic            stopped_in;

   drbof_pkg::bundle_type bnd;
   logic [2:0]            n_out;
   logic [15:0]           raw_len;
   logic [15:0]           name_next;
   logic [1:0]            held;
   logic                  in_header;
   logic                  short_len;

   function automatic logic [1:0] held_count(logic [15:0] off, logic stopped);
      logic [1:0] c;
      c = '0;
      if (!stopped && off < 16'(drbof_pkg::HEADER_BYTES)) begin
         if (!off[2]) c = off[1:0];
         else         c = {1'b0, off[0]};
      end
      return c;
   endfunction

   function automatic logic [1:0] held_start(logic [15:0] off);
      return (off[2] && off[1]) ? 2'd2 : 2'd0;
   endfunction

   function automatic logic [3:0][7:0] gather(logic [3:0][7:0] src, logic [1:0] cnt,
                                              logic [1:0] start, logic [7:0] tail);
      logic [3:0][7:0] r;
      logic [1:0]      pos;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         pos = start + 2'(i);
         if (i < int'(cnt)) r[i] = src[pos];
         else if (i == int'(cnt)) r[i] = tail;
      end
      return r;
   endfunction

   function automatic logic [3:0][7:0] long_perm(logic [3:0][7:0] src, logic [7:0] c_ord,
                                                 logic [7:0] s_ord);
      logic [3:0][7:0] r;
      r = '0;
      for (int k = 0; k < 4; k++) begin
         r[c_ord[2*k +: 2]] = src[s_ord[2*k +: 2]];
      end
      return r;
   endfunction

   function automatic logic [1:0][7:0] short_perm(logic [3:0][7:0] src, logic hi,
                                                  logic [7:0] c_ord, logic [7:0] s_ord);
      logic [1:0][7:0] r;
      r = '0;
      for (int k = 0; k < 2; k++) begin
         r[c_ord[2*k]] = src[{hi, s_ord[2*k]}];
      end
      return r;
   endfunction

   assign in_header = offset_ff < 16'(drbof_pkg::HEADER_BYTES);
   assign raw_len   = cfg.native_little_endian ? {in_byte, fbuf_ff[0]} : {fbuf_ff[0], in_byte};
   assign short_len = length_ff < 16'(drbof_pkg::HEADER_BYTES);
   assign name_next = offset_ff + 16'd1;

   always_comb begin
      bnd        = '0;
      n_out      = '0;
      held       = '0;
      fbuf_in    = fbuf_ff;
      offset_in  = offset_ff;
      length_in  = length_ff;
      stopped_in = stopped_ff;
      if (!cfg.is_directory || !cfg.client_known) begin
         held       = held_count(offset_ff, stopped_ff);
         bnd.bytes  = gather(fbuf_ff, held, held_start(offset_ff), in_byte);
         bnd.status = cfg.is_directory ? drbof_pkg::STATUS_UNKNOWN : drbof_pkg::STATUS_OK;
         n_out      = {1'b0, held} + 3'd1;
         fbuf_in    = '0;
         offset_in  = '0;
         length_in  = '0;
         stopped_in = 1'b0;
      end else if (stopped_ff) begin
         bnd.bytes[0] = in_byte;
         bnd.status   = drbof_pkg::STATUS_STOPPED;
         n_out        = 3'd1;
      end else if (in_header) begin
         fbuf_in[offset_ff[1:0]] = in_byte;
         case (offset_ff[2:0])
            3'd3: begin
               bnd.bytes = long_perm(fbuf_in, cfg.client_order, cfg.server_order);
               n_out     = 3'd4;
            end
            3'd5: begin
               length_in      = raw_len;
               bnd.bytes[1:0] = short_perm(fbuf_in, 1'b0, cfg.client_order,
                                           cfg.server_order);
               bnd.status     = (raw_len < 16'(drbof_pkg::HEADER_BYTES)) ?
                                drbof_pkg::STATUS_STOPPED : drbof_pkg::STATUS_OK;
               n_out          = 3'd2;
            end
            3'd7: begin
               bnd.bytes[1:0] = short_perm(fbuf_in, 1'b1, cfg.client_order,
                                           cfg.server_order);
               bnd.status     = short_len ? drbof_pkg::STATUS_STOPPED : drbof_pkg::STATUS_OK;
               n_out          = 3'd2;
            end
            default: begin
               n_out = '0;
            end
         endcase
         if (offset_ff[2:0] == 3'd7) begin
            if (short_len) begin
               stopped_in = 1'b1;
               offset_in  = '0;
            end else if (length_ff == 16'(drbof_pkg::HEADER_BYTES)) begin
               offset_in = '0;
            end else begin
               offset_in = 16'(drbof_pkg::HEADER_BYTES);
            end
         end else begin
            offset_in = name_next;
         end
      end else begin
         bnd.bytes[0] = in_byte;
         n_out        = 3'd1;
         offset_in    = (name_next >= length_ff) ? 16'd0 : name_next;
      end

      if (in_last) begin
         // flush held header bytes when nothing else came out for this byte
         if (n_out == 3'd0) begin
            held       = held_count(offset_in, stopped_in);
            bnd.bytes  = gather(fbuf_in, held, held_start(offset_in), 8'd0);
            bnd.status = stopped_in ? drbof_pkg::STATUS_STOPPED : drbof_pkg::STATUS_OK;
            n_out      = {1'b0, held};
         end
         bnd.last   = 1'b1;
         fbuf_in    = '0;
         offset_in  = '0;
         length_in  = '0;
         stopped_in = 1'b0;
      end
      bnd.last_idx = 2'(n_out - 3'd1);
   end

   assign q_push = accept && (n_out != 3'd0);
   assign q_data = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         fbuf_ff    <= '0;
         offset_ff  <= '0;
         length_ff  <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         fbuf_ff    <= fbuf_in;
         offset_ff  <= offset_in;
         length_ff  <= length_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

FILE: rtl/drbof_queue.sv
// Short bundle queue between the front end and the serialiser.
// Depends on drbof_pkg for bundle_type.
module drbof_queue #(
   parameter int unsigned DEPTH = drbof_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  drbof_pkg::bundle_type push_data,
   input  logic                  pop,
   output drbof_pkg::bundle_type head,
   output logic                  full,
   output logic                  valid
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   drbof_pkg::bundle_type entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign valid   = count_ff != '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("bundle pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !valid))
      else $error("bundle popped from an empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue fill count did not advance on a lone push");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");
`endif

endmodule

FILE: rtl/drbof_back.sv
// Back end: takes bundles from the queue and gives out one result byte per
// transfer from a registered output stage. Depends on drbof_pkg.
module drbof_back (
   input  logic                  clock,
   input  logic                  reset,
   input  drbof_pkg::bundle_type q_head,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  logic                  pop,
   output logic                  empty,
   output logic [7:0]            out_byte,
   output logic                  out_last,
   output logic [1:0]            status
);

   drbof_pkg::bundle_type cur_ff;
   drbof_pkg::bundle_type cur_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic [1:0]            idx_ff;
   logic [1:0]            idx_in;
   logic                  xfer;
   logic                  done;
   logic                  load;

   assign xfer  = pop && valid_ff;
   assign done  = xfer && (idx_ff == cur_ff.last_idx);
   assign load  = (!valid_ff || done) && q_valid;
   assign q_pop = load;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         cur_in   = q_head;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (done) begin
         valid_in = 1'b0;
         idx_in   = '0;
      end else if (xfer) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   assign empty    = !valid_ff;
   assign out_byte = cur_ff.bytes[idx_ff];
   assign out_last = cur_ff.last && (idx_ff == cur_ff.last_idx);
   assign status   = cur_ff.status;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: rtl/directory_record_byte_order_fixer_top.sv
// Top level of the directory record byte-order fixer.
// Depends on drbof_pkg, drbof_csr, drbof_front, drbof_queue and drbof_back.
//
// Takes one buffer byte per cycle whenever full is low; the front end turns
// each byte into a bundle of zero to four result bytes (four when an inode
// completes, two for each short header field, one for a name or passed
// byte) and the back end gives out one result byte per cycle while pop is
// high, so the sustained rate is set by the result side. A queue of
// QUEUE_DEPTH bundles absorbs the four-byte inode bursts; a byte reaches the
// result ports via a queue entry and the back-end output register. Users
// write configuration through the APB-style port while idle; not enforced.
module directory_record_byte_order_fixer_top #(
   parameter int unsigned QUEUE_DEPTH = drbof_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [7:0]                            req_in_byte,
   input  logic                                  req_in_last,
   output logic                                  empty,
   input  logic                                  pop,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_out_last,
   output logic [1:0]                            rsp_status,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [drbof_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [drbof_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [drbof_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                  pready
);

   drbof_pkg::cfg_type    cfg;
   drbof_pkg::bundle_type q_data;
   drbof_pkg::bundle_type q_head;
   logic                  accept;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_valid;

   assign accept = push && !full;

   drbof_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   drbof_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (accept),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .q_push  (q_push),
      .q_data  (q_data)
   );

   drbof_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (full),
      .valid     (q_valid)
   );

   drbof_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .out_byte (rsp_out_byte),
      .out_last (rsp_out_last),
      .status   (rsp_status)
   );

endmodule
